[hw/rtl/rsa_pkg.sv]
// Shared types and constants of the reference-counted slot allocator.
// Used by the channel interfaces, the controller, the datapath and the top level.
package rsa_pkg;

    localparam int SLOT_COUNT_DEF  = 4096;
    localparam int SLOT_BYTES_LOG2 = 7;
    localparam int SLOT_BYTES      = 1 << SLOT_BYTES_LOG2;
    localparam int RESERVED_SLOTS  = 2;
    localparam int HEADER_BYTES    = 16;

    localparam int OP_W     = 2;
    localparam int REQ_W    = 19;
    localparam int SLOT_W   = 12;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 16;
    localparam int SPAN_W   = 13;
    localparam int SUM_W    = REQ_W + 1;
    localparam int SPAN_MAX = 8191;

    localparam logic [COUNT_W-1:0] COUNT_FREE = 16'hFFFF;
    localparam logic [COUNT_W-1:0] COUNT_MAX  = 16'h7FFF;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC   = 2'd0,
        OP_RETAIN  = 2'd1,
        OP_RELEASE = 2'd2,
        OP_UNUSED  = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK           = 2'd0,
        ST_NO_SPACE     = 2'd1,
        ST_FREE_RELEASE = 2'd2,
        ST_SATURATED    = 2'd3
    } t_status;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [SPAN_W-1:0]  span;
        logic               dflag;
    } t_entry;

    typedef enum logic [1:0] {
        A_CLR,
        A_POS,
        A_PROBE,
        A_SLOT
    } t_addr_sel;

    typedef enum logic [1:0] {
        W_CLR,
        W_GRANT,
        W_RMW
    } t_wdata_sel;

    typedef enum logic [2:0] {
        RK_ALLOC_FAIL,
        RK_IDX_FAIL,
        RK_ECHO_OK,
        RK_GRANT,
        RK_RMW
    } t_res_kind;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic       load;
        logic       clr_inc;
        logic       mem_we;
        t_addr_sel  addr_sel;
        t_wdata_sel wdata_sel;
        logic       pass2;
        logic       skip_res;
        logic       jump;
        logic       start_probe;
        logic       probe_inc;
        logic       probe_to_pos;
        logic       grant_start;
        logic       cursor_upd;
        logic       res_we;
        t_res_kind  res_kind;
        logic       push;
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic clr_last;
        t_op  op;
        logic len_ok;
        logic idx_ok;
        logic pos_lt_end;
        logic pass2;
        logic pos_reserved;
        logic rd_free;
        logic probe_done;
        logic probe_past_end;
        logic grant_last;
        logic out_free;
    } t_stat;

endpackage

[hw/rtl/rsa_if.sv]
// Request and response channel interfaces of the slot allocator.
// Depends on rsa_pkg for the field widths.
interface rsa_req_if;
    logic                         valid;
    logic                         ready;
    logic [rsa_pkg::OP_W-1:0]     operation;
    logic [rsa_pkg::REQ_W-1:0]    request_bytes;
    logic                         has_destructor;
    logic [rsa_pkg::SLOT_W-1:0]   slot_index;

    modport source (output valid, operation, request_bytes, has_destructor, slot_index,
                    input ready);
    modport sink   (input valid, operation, request_bytes, has_destructor, slot_index,
                    output ready);
endinterface

interface rsa_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [rsa_pkg::STATUS_W-1:0] status;
    logic [rsa_pkg::SLOT_W-1:0]   result_slot;
    logic                         became_free;
    logic                         run_destructor;

    modport source (output valid, status, result_slot, became_free, run_destructor,
                    input ready);
    modport sink   (input valid, status, result_slot, became_free, run_destructor,
                    output ready);
endinterface

[hw/rtl/refcounted_slot_allocator_core.sv]
// Reference-counted slot allocator, top level: rsa_ctrl sequencer plus rsa_dp datapath.
// Retain/release read the slot and write it back; a new item is taken only back in idle.
// Allocate reads each slot header or run slot examined and writes each granted slot, with one
// more step per reserved skip, pass wrap or run given up; oversized requests skip the scan.
// Reset (sync, active low) starts a clear sweep over every slot; no item is taken meanwhile.
// Depends on rsa_pkg, rsa_if, rsa_ctrl, rsa_dp.
module refcounted_slot_allocator_core #(
    parameter int SLOT_COUNT = rsa_pkg::SLOT_COUNT_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rsa_req_if.sink   i_req,
    rsa_rsp_if.source o_rsp
);

    // Command and status between the sequencer and the datapath
    rsa_pkg::t_cmd  w_cmd;
    rsa_pkg::t_stat w_stat;
    logic           w_req_ready;

    // Sequencer: owns the request handshake and walks the store.
    // After the clear sweep it waits in idle; an allocate then scans
    // from the cursor to the end of the store, wraps once to slot zero,
    // probes each candidate run one slot at a time and writes the run
    // one slot per cycle. Retain and release take one read and one write.
    // All work shares one single-port slot store, one access per cycle.
    rsa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (w_req_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    assign i_req.ready = w_req_ready;

    // Datapath: latches the request on accept, holds the slot store,
    // the scan pointers and the cursor, and stages the result. The
    // output register lets the next item be accepted while a result
    // still waits to be taken.
    rsa_dp #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .i_operation      (i_req.operation),
        .i_request_bytes  (i_req.request_bytes),
        .i_has_destructor (i_req.has_destructor),
        .i_slot_index     (i_req.slot_index),
        .o_rsp            (o_rsp)
    );

endmodule

[hw/rtl/rsa_ctrl.sv]
// Sequencing state machine of the slot allocator: clear sweep, search, grant, update.
// Depends on rsa_pkg for the command and status structs.
module rsa_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    output logic           o_req_ready,
    input  rsa_pkg::t_stat i_stat,
    output rsa_pkg::t_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_HEAD,
        S_PROBE,
        S_PROBE_EV,
        S_GRANT,
        S_RMW_RD,
        S_RMW_WR,
        S_FINISH
    } t_state;

    t_state        r_state;
    t_state        n_state;
    logic          r_ready;
    logic          n_ready;
    rsa_pkg::t_cmd w_cmd;

    always_comb begin
        n_state = r_state;
        w_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                w_cmd.mem_we    = 1'b1;
                w_cmd.addr_sel  = rsa_pkg::A_CLR;
                w_cmd.wdata_sel = rsa_pkg::W_CLR;
                w_cmd.clr_inc   = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req_valid && r_ready) begin
                    w_cmd.load = 1'b1;
                    n_state    = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (i_stat.op)
                    rsa_pkg::OP_ALLOC: begin
                        if (i_stat.len_ok) begin
                            n_state = S_SCAN;
                        end else begin
                            w_cmd.res_we   = 1'b1;
                            w_cmd.res_kind = rsa_pkg::RK_ALLOC_FAIL;
                            n_state        = S_FINISH;
                        end
                    end
                    rsa_pkg::OP_RETAIN, rsa_pkg::OP_RELEASE: begin
                        if (i_stat.idx_ok) begin
                            n_state = S_RMW_RD;
                        end else begin
                            w_cmd.res_we   = 1'b1;
                            w_cmd.res_kind = rsa_pkg::RK_IDX_FAIL;
                            n_state        = S_FINISH;
                        end
                    end
                    default: begin
                        w_cmd.res_we   = 1'b1;
                        w_cmd.res_kind = rsa_pkg::RK_ECHO_OK;
                        n_state        = S_FINISH;
                    end
                endcase
            end
            S_SCAN: begin
                if (!i_stat.pos_lt_end) begin
                    // end of this pass: wrap to slot zero once, then give up
                    if (!i_stat.pass2) begin
                        w_cmd.pass2 = 1'b1;
                    end else begin
                        w_cmd.res_we   = 1'b1;
                        w_cmd.res_kind = rsa_pkg::RK_ALLOC_FAIL;
                        n_state        = S_FINISH;
                    end
                end else if (i_stat.pos_reserved) begin
                    w_cmd.skip_res = 1'b1;
                end else begin
                    w_cmd.addr_sel = rsa_pkg::A_POS;
                    n_state        = S_HEAD;
                end
            end
            S_HEAD: begin
                if (i_stat.rd_free) begin
                    w_cmd.start_probe = 1'b1;
                    n_state           = S_PROBE;
                end else begin
                    w_cmd.jump = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_PROBE: begin
                if (i_stat.probe_done) begin
                    w_cmd.grant_start = 1'b1;
                    n_state           = S_GRANT;
                end else if (i_stat.probe_past_end) begin
                    w_cmd.probe_to_pos = 1'b1;
                    n_state            = S_SCAN;
                end else begin
                    w_cmd.addr_sel = rsa_pkg::A_PROBE;
                    n_state        = S_PROBE_EV;
                end
            end
            S_PROBE_EV: begin
                if (i_stat.rd_free) begin
                    w_cmd.probe_inc = 1'b1;
                    n_state         = S_PROBE;
                end else begin
                    // restart the scan at the blocking slot
                    w_cmd.probe_to_pos = 1'b1;
                    n_state            = S_SCAN;
                end
            end
            S_GRANT: begin
                w_cmd.mem_we    = 1'b1;
                w_cmd.addr_sel  = rsa_pkg::A_PROBE;
                w_cmd.wdata_sel = rsa_pkg::W_GRANT;
                w_cmd.probe_inc = 1'b1;
                if (i_stat.grant_last) begin
                    w_cmd.cursor_upd = 1'b1;
                    w_cmd.res_we     = 1'b1;
                    w_cmd.res_kind   = rsa_pkg::RK_GRANT;
                    n_state          = S_FINISH;
                end
            end
            S_RMW_RD: begin
                w_cmd.addr_sel = rsa_pkg::A_SLOT;
                n_state        = S_RMW_WR;
            end
            S_RMW_WR: begin
                w_cmd.mem_we    = 1'b1;
                w_cmd.addr_sel  = rsa_pkg::A_SLOT;
                w_cmd.wdata_sel = rsa_pkg::W_RMW;
                w_cmd.res_we    = 1'b1;
                w_cmd.res_kind  = rsa_pkg::RK_RMW;
                n_state         = S_FINISH;
            end
            S_FINISH: begin
                if (i_stat.out_free) begin
                    w_cmd.push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_ready = (n_state == S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_ready <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ready <= n_ready;
        end
    end

    assign o_req_ready = r_ready;
    assign o_cmd       = w_cmd;

endmodule

[hw/rtl/rsa_dp.sv]
// Datapath of the slot allocator: slot store, scan pointers, cursor, result registers.
// Depends on rsa_pkg and rsa_rsp_if; driven by rsa_ctrl commands.
module rsa_dp #(
    parameter int SLOT_COUNT = rsa_pkg::SLOT_COUNT_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  rsa_pkg::t_cmd               i_cmd,
    output rsa_pkg::t_stat              o_stat,
    input  logic [rsa_pkg::OP_W-1:0]    i_operation,
    input  logic [rsa_pkg::REQ_W-1:0]   i_request_bytes,
    input  logic                        i_has_destructor,
    input  logic [rsa_pkg::SLOT_W-1:0]  i_slot_index,
    rsa_rsp_if.source                   o_rsp
);

    localparam int IDX_W = $clog2(SLOT_COUNT);
    localparam int PW    = IDX_W + 1;
    localparam logic [PW-1:0] SC_P = PW'(SLOT_COUNT);

    // request
    rsa_pkg::t_op                  r_op;
    logic [rsa_pkg::SPAN_W-1:0]    r_len;
    logic                          r_len_ok;
    logic                          r_dtor;
    logic [rsa_pkg::SLOT_W-1:0]    r_slot_in;
    logic                          r_idx_ok;
    // scan
    logic [PW-1:0]                 r_pos;
    logic [PW-1:0]                 r_end;
    logic [PW-1:0]                 r_probe;
    logic [PW-1:0]                 r_stop;
    logic [IDX_W-1:0]              r_head;
    logic                          r_pass2;
    logic [IDX_W-1:0]              r_cursor;
    logic [IDX_W-1:0]              r_clr;
    // store
    rsa_pkg::t_entry               r_mem [SLOT_COUNT];
    rsa_pkg::t_entry               r_rdata;
    // result staging and output register
    rsa_pkg::t_status              r_res_status;
    logic [rsa_pkg::SLOT_W-1:0]    r_res_slot;
    logic                          r_res_freed;
    logic                          r_res_rund;
    logic                          r_out_valid;
    rsa_pkg::t_status              r_out_status;
    logic [rsa_pkg::SLOT_W-1:0]    r_out_slot;
    logic                          r_out_freed;
    logic                          r_out_rund;

    logic [rsa_pkg::SUM_W-1:0]     w_sum;
    logic [rsa_pkg::SUM_W-1:0]     w_len_full;
    logic                          w_len_ok;
    logic [rsa_pkg::SPAN_W-1:0]    w_len;
    logic [PW-1:0]                 w_end1;
    logic [PW-1:0]                 w_span_step;
    logic [IDX_W-1:0]              w_addr;
    rsa_pkg::t_entry               w_wdata;
    logic [rsa_pkg::COUNT_W-1:0]   w_rmw_count;
    rsa_pkg::t_status              w_rmw_status;
    logic                          w_rmw_freed;
    logic                          w_rmw_rund;

    // Header plus payload, rounded up to whole slots
    assign w_sum      = rsa_pkg::SUM_W'(i_request_bytes)
                      + rsa_pkg::SUM_W'(rsa_pkg::HEADER_BYTES + rsa_pkg::SLOT_BYTES - 1);
    assign w_len_full = w_sum >> rsa_pkg::SLOT_BYTES_LOG2;
    assign w_len_ok   = (w_len_full != '0)
                      && (w_len_full <= rsa_pkg::SUM_W'(SLOT_COUNT - rsa_pkg::RESERVED_SLOTS))
                      && (w_len_full <= rsa_pkg::SUM_W'(rsa_pkg::SPAN_MAX));
    assign w_len      = rsa_pkg::SPAN_W'(w_len_full);
    assign w_end1     = SC_P - PW'(w_len) + PW'(1);

    assign w_span_step = (r_rdata.span == '0) ? PW'(1) : PW'(r_rdata.span);

    always_comb begin
        case (i_cmd.addr_sel)
            rsa_pkg::A_CLR:   w_addr = r_clr;
            rsa_pkg::A_POS:   w_addr = r_pos[IDX_W-1:0];
            rsa_pkg::A_PROBE: w_addr = r_probe[IDX_W-1:0];
            rsa_pkg::A_SLOT:  w_addr = IDX_W'(r_slot_in);
            default:          w_addr = r_clr;
        endcase
    end

    // Retain and release on the count read back from the store
    always_comb begin
        w_rmw_count  = r_rdata.count;
        w_rmw_status = rsa_pkg::ST_OK;
        w_rmw_freed  = 1'b0;
        w_rmw_rund   = 1'b0;
        if (r_op == rsa_pkg::OP_RETAIN) begin
            if (r_rdata.count == rsa_pkg::COUNT_FREE) begin
                w_rmw_count = '0;
            end else if (r_rdata.count >= rsa_pkg::COUNT_MAX) begin
                w_rmw_status = rsa_pkg::ST_SATURATED;
            end else begin
                w_rmw_count = r_rdata.count + 1'b1;
            end
        end else begin
            if (r_rdata.count == rsa_pkg::COUNT_FREE) begin
                w_rmw_status = rsa_pkg::ST_FREE_RELEASE;
            end else if (r_rdata.count == '0) begin
                w_rmw_count = rsa_pkg::COUNT_FREE;
                w_rmw_freed = 1'b1;
                w_rmw_rund  = r_rdata.dflag;
            end else begin
                w_rmw_count = r_rdata.count - 1'b1;
            end
        end
    end

    always_comb begin
        case (i_cmd.wdata_sel)
            rsa_pkg::W_CLR: begin
                w_wdata.count = rsa_pkg::COUNT_FREE;
                w_wdata.span  = rsa_pkg::SPAN_W'(1);
                w_wdata.dflag = 1'b0;
            end
            rsa_pkg::W_GRANT: begin
                w_wdata.count = '0;
                if (r_probe == {1'b0, r_head}) begin
                    w_wdata.span  = r_len;
                    w_wdata.dflag = r_dtor;
                end else begin
                    w_wdata.span  = '0;
                    w_wdata.dflag = 1'b0;
                end
            end
            rsa_pkg::W_RMW: begin
                w_wdata.count = w_rmw_count;
                w_wdata.span  = r_rdata.span;
                w_wdata.dflag = r_rdata.dflag;
            end
            default: begin
                w_wdata = r_rdata;
            end
        endcase
    end

    // Slot store: one access per cycle, registered read data
    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_we) begin
            r_mem[w_addr] <= w_wdata;
        end
        r_rdata <= r_mem[w_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor <= '0;
            r_clr    <= '0;
        end else begin
            if (i_cmd.clr_inc) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cmd.cursor_upd) begin
                r_cursor <= (r_stop >= SC_P) ? '0 : r_stop[IDX_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op      <= rsa_pkg::t_op'(i_operation);
            r_len     <= w_len;
            r_len_ok  <= w_len_ok;
            r_dtor    <= i_has_destructor;
            r_slot_in <= i_slot_index;
            r_idx_ok  <= (32'(i_slot_index) < SLOT_COUNT);
        end

        if (i_cmd.load) begin
            r_pos   <= {1'b0, r_cursor};
            r_end   <= w_end1;
            r_pass2 <= 1'b0;
        end else if (i_cmd.pass2) begin
            r_pos   <= '0;
            r_end   <= {1'b0, r_cursor};
            r_pass2 <= 1'b1;
        end else if (i_cmd.skip_res) begin
            r_pos <= PW'(rsa_pkg::RESERVED_SLOTS);
        end else if (i_cmd.jump) begin
            r_pos <= r_pos + w_span_step;
        end else if (i_cmd.probe_to_pos) begin
            r_pos <= r_probe;
        end

        if (i_cmd.start_probe) begin
            r_head  <= r_pos[IDX_W-1:0];
            r_probe <= r_pos + PW'(1);
            r_stop  <= r_pos + PW'(r_len);
        end else if (i_cmd.grant_start) begin
            r_probe <= {1'b0, r_head};
        end else if (i_cmd.probe_inc) begin
            r_probe <= r_probe + PW'(1);
        end

        if (i_cmd.res_we) begin
            case (i_cmd.res_kind)
                rsa_pkg::RK_ALLOC_FAIL: begin
                    r_res_status <= rsa_pkg::ST_NO_SPACE;
                    r_res_slot   <= '0;
                    r_res_freed  <= 1'b0;
                    r_res_rund   <= 1'b0;
                end
                rsa_pkg::RK_IDX_FAIL: begin
                    r_res_status <= rsa_pkg::ST_NO_SPACE;
                    r_res_slot   <= r_slot_in;
                    r_res_freed  <= 1'b0;
                    r_res_rund   <= 1'b0;
                end
                rsa_pkg::RK_GRANT: begin
                    r_res_status <= rsa_pkg::ST_OK;
                    r_res_slot   <= rsa_pkg::SLOT_W'(r_head);
                    r_res_freed  <= 1'b0;
                    r_res_rund   <= 1'b0;
                end
                rsa_pkg::RK_RMW: begin
                    r_res_status <= w_rmw_status;
                    r_res_slot   <= r_slot_in;
                    r_res_freed  <= w_rmw_freed;
                    r_res_rund   <= w_rmw_rund;
                end
                default: begin
                    r_res_status <= rsa_pkg::ST_OK;
                    r_res_slot   <= r_slot_in;
                    r_res_freed  <= 1'b0;
                    r_res_rund   <= 1'b0;
                end
            endcase
        end

        if (i_cmd.push) begin
            r_out_status <= r_res_status;
            r_out_slot   <= r_res_slot;
            r_out_freed  <= r_res_freed;
            r_out_rund   <= r_res_rund;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.status         = r_out_status;
    assign o_rsp.result_slot    = r_out_slot;
    assign o_rsp.became_free    = r_out_freed;
    assign o_rsp.run_destructor = r_out_rund;

    assign o_stat.clr_last       = (r_clr == IDX_W'(SLOT_COUNT - 1));
    assign o_stat.op             = r_op;
    assign o_stat.len_ok         = r_len_ok;
    assign o_stat.idx_ok         = r_idx_ok;
    assign o_stat.pos_lt_end     = (r_pos < r_end);
    assign o_stat.pass2          = r_pass2;
    assign o_stat.pos_reserved   = (32'(r_pos) < rsa_pkg::RESERVED_SLOTS);
    assign o_stat.rd_free        = (r_rdata.count == rsa_pkg::COUNT_FREE);
    assign o_stat.probe_done     = (r_probe == r_stop);
    assign o_stat.probe_past_end = (r_probe >= SC_P);
    assign o_stat.grant_last     = ((r_probe + PW'(1)) == r_stop);
    assign o_stat.out_free       = !r_out_valid || o_rsp.ready;

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_cursor} < SC_P)
        else $error("search cursor left the store");

    a_grant_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.mem_we && i_cmd.wdata_sel == rsa_pkg::W_GRANT)
        |-> (r_probe < r_stop) && (r_probe >= {1'b0, r_head}) && (r_probe < SC_P))
        else $error("grant write outside the granted run");

    a_rund_needs_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_rund) |-> r_out_freed)
        else $error("destructor reported without a free");

    a_free_is_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_freed) |-> (r_out_status == rsa_pkg::ST_OK))
        else $error("free reported with an error status");

endmodule

[tb/slot_ledger_check.sv]
`timescale 1ns / 1ps
// Checker of the slot allocator: mirrors the slot store, predicts every result and
// compares it with the response channel. Depends on rsa_pkg and rsa_if.
module slot_ledger_check #(
    parameter int SLOT_COUNT = rsa_pkg::SLOT_COUNT_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    rsa_req_if   i_req,
    rsa_rsp_if   i_rsp,
    output int   o_fail_count,
    output int   o_expected_left
);
    import rsa_pkg::*;

    typedef struct packed {
        t_status           status;
        logic [SLOT_W-1:0] slot;
        logic              freed;
        logic              dtor;
    } t_outcome;

    logic [COUNT_W-1:0] ref_cnt [SLOT_COUNT];
    logic [SPAN_W-1:0]  span_of [SLOT_COUNT];
    logic               dtor_of [SLOT_COUNT];
    int unsigned        cursor;
    t_outcome           promised_results [$];
    int                 fails = 0;
    int                 waiting_n = 0;

    assign o_fail_count    = fails;
    assign o_expected_left = waiting_n;

    task automatic report_mismatch(input string what);
        $display("%0t ns mismatch: %s", $time, what);
        fails++;
    endtask

    // True when len slots from start are all free; slots past the end count as taken.
    function automatic bit run_clear(input int unsigned start, input int unsigned len);
        int unsigned i;
        for (i = 0; i < len; i++) begin
            if (start + i >= SLOT_COUNT || ref_cnt[start + i] != COUNT_FREE)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // One next-fit pass over [from, upto); returns the head slot or -1.
    function automatic int find_run(input int unsigned from, input int unsigned upto,
                                    input int unsigned len);
        int unsigned pos;
        pos = from;
        while (pos < upto && pos < SLOT_COUNT) begin
            if (pos < RESERVED_SLOTS) begin
                pos++;
            end else if (ref_cnt[pos] == COUNT_FREE) begin
                if (run_clear(pos, len))
                    return int'(pos);
                pos++;
            end else begin
                pos += (span_of[pos] == '0) ? 1 : int'(span_of[pos]);
            end
        end
        return -1;
    endfunction

    function automatic t_outcome apply_request(input t_op op, input int unsigned bytes,
                                               input logic dtor, input int unsigned idx);
        t_outcome    res;
        int unsigned len;
        int unsigned i;
        int          head;
        res.status = ST_OK;
        res.slot   = SLOT_W'(idx);
        res.freed  = 1'b0;
        res.dtor   = 1'b0;
        case (op)
            OP_ALLOC: begin
                len  = (bytes + HEADER_BYTES + SLOT_BYTES - 1) / SLOT_BYTES;
                head = -1;
                res.slot = '0;
                if (len != 0 && len <= SLOT_COUNT - RESERVED_SLOTS && len <= SPAN_MAX) begin
                    head = find_run(cursor, SLOT_COUNT - (len - 1), len);
                    if (head < 0)
                        head = find_run(0, cursor, len);
                end
                if (head < 0) begin
                    res.status = ST_NO_SPACE;
                end else begin
                    for (i = 0; i < len; i++) begin
                        ref_cnt[head + i] = '0;
                        span_of[head + i] = (i == 0) ? SPAN_W'(len) : '0;
                        dtor_of[head + i] = (i == 0) ? dtor : 1'b0;
                    end
                    cursor   = (head + len >= SLOT_COUNT) ? 0 : head + len;
                    res.slot = SLOT_W'(head);
                end
            end
            OP_RETAIN: begin
                if (idx >= SLOT_COUNT)
                    res.status = ST_NO_SPACE;
                else if (ref_cnt[idx] == COUNT_FREE)
                    ref_cnt[idx] = '0;
                else if (ref_cnt[idx] >= COUNT_MAX)
                    res.status = ST_SATURATED;
                else
                    ref_cnt[idx] = ref_cnt[idx] + 1'b1;
            end
            OP_RELEASE: begin
                if (idx >= SLOT_COUNT) begin
                    res.status = ST_NO_SPACE;
                end else if (ref_cnt[idx] == COUNT_FREE) begin
                    res.status = ST_FREE_RELEASE;
                end else if (ref_cnt[idx] == '0) begin
                    // flag and span stay behind in the freed slot
                    ref_cnt[idx] = COUNT_FREE;
                    res.freed    = 1'b1;
                    res.dtor     = dtor_of[idx];
                end else begin
                    ref_cnt[idx] = ref_cnt[idx] - 1'b1;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_outcome want;
        int n;
        if (!i_rst_n) begin
            for (n = 0; n < SLOT_COUNT; n++) begin
                ref_cnt[n] = COUNT_FREE;
                span_of[n] = SPAN_W'(1);
                dtor_of[n] = 1'b0;
            end
            cursor = 0;
            promised_results.delete();
        end else begin
            if (i_req.valid && i_req.ready)
                promised_results.push_back(apply_request(t_op'(i_req.operation),
                    i_req.request_bytes, i_req.has_destructor, i_req.slot_index));
            if (i_rsp.valid && i_rsp.ready) begin
                if (promised_results.size() == 0) begin
                    report_mismatch($sformatf("result with nothing pending, slot %0d",
                                              i_rsp.result_slot));
                end else begin
                    want = promised_results.pop_front();
                    if (i_rsp.status !== want.status)
                        report_mismatch($sformatf("status %0d, want %0d (slot %0d)",
                                                  i_rsp.status, want.status, want.slot));
                    if (i_rsp.result_slot !== want.slot)
                        report_mismatch($sformatf("result_slot %0d, want %0d",
                                                  i_rsp.result_slot, want.slot));
                    if (i_rsp.became_free !== want.freed)
                        report_mismatch($sformatf("became_free %0b, want %0b (slot %0d)",
                                                  i_rsp.became_free, want.freed, want.slot));
                    if (i_rsp.run_destructor !== want.dtor)
                        report_mismatch($sformatf("run_destructor %0b, want %0b (slot %0d)",
                                                  i_rsp.run_destructor, want.dtor, want.slot));
                end
            end
        end
        waiting_n = promised_results.size();
    end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// Top of the slot allocator testbench: clock, reset, request stimulus and verdict.
// Depends on rsa_pkg, rsa_if, refcounted_slot_allocator_core and slot_ledger_check.
module tb;
    import rsa_pkg::*;

    localparam int SLOTS        = SLOT_COUNT_DEF;
    localparam int TOP_SLOT     = SLOTS - 1;
    // An allocate can walk the whole store, and the clear sweep after reset
    // writes every slot once. Both stay far below this.
    localparam int STALL_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 64;
    localparam int PHASE_ITEMS  = 517;
    localparam int MAX_LIVE     = 40;
    localparam int unsigned REQ_TOP      = 524272;
    // Smallest request whose run no longer fits beside the reserved slots
    localparam int unsigned OVERSIZE_MIN = (SLOTS - RESERVED_SLOTS) * SLOT_BYTES
                                           - HEADER_BYTES + 1;
    localparam int unsigned SMALL_TOP    = 4 * SLOT_BYTES - HEADER_BYTES;
    localparam int unsigned MEDIUM_TOP   = 32 * SLOT_BYTES - HEADER_BYTES;

    typedef struct {
        bit          track;
        bit          is_alloc;
        int unsigned len;
    } t_sent;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    int   send_idle_pct = 7;
    int   recv_idle_pct = 71;
    int   fail_count;
    int   expected_left;
    int   stall_cycles = 0;

    // Handles of objects that the random part owns, with the count it expects
    t_sent       sent_log [$];
    int unsigned live_slot [$];
    int unsigned live_refs [$];
    int unsigned live_len [$];
    // Body slots of freed multi-slot objects, still to be released one by one
    int unsigned orphan_slots [$];

    rsa_req_if req_ch ();
    rsa_rsp_if rsp_ch ();

    refcounted_slot_allocator_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    slot_ledger_check #(.SLOT_COUNT(SLOTS)) ledger_chk (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req           (req_ch),
        .i_rsp           (rsp_ch),
        .o_fail_count    (fail_count),
        .o_expected_left (expected_left)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Receiver: drop ready at random, redrawn at every falling edge
    initial begin
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            rsp_ch.ready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Learn the head slot of every tracked allocate from its result
    always @(posedge i_clk) begin
        t_sent s;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready && sent_log.size() > 0) begin
            s = sent_log.pop_front();
            if (s.track && s.is_alloc && rsp_ch.status == ST_OK) begin
                live_slot.push_back(rsp_ch.result_slot);
                live_refs.push_back(0);
                live_len.push_back(s.len);
            end
        end
    end

    // Watchdog: end the run when no item moves on either channel for too long
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic int unsigned bytes_for(input int unsigned n);
        return n * SLOT_BYTES - HEADER_BYTES;
    endfunction

    // Drive one item at the falling edge and hold it until accepted; valid stays
    // high on return so that back-to-back items leave no gap.
    task automatic send_request(input t_op op, input int unsigned bytes, input bit dtor,
                                input int unsigned idx, input bit track);
        t_sent s;
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid          = 1'b1;
        req_ch.operation      = op;
        req_ch.request_bytes  = REQ_W'(bytes);
        req_ch.has_destructor = dtor;
        req_ch.slot_index     = SLOT_W'(idx);
        do @(posedge i_clk); while (!req_ch.ready);
        s.track    = track;
        s.is_alloc = (op == OP_ALLOC);
        s.len      = (bytes + HEADER_BYTES + SLOT_BYTES - 1) / SLOT_BYTES;
        sent_log.push_back(s);
    endtask

    // Mostly well-formed object lifetimes: allocate, retain, release down to free,
    // then release the body slots. A small share is noise on random slots.
    task automatic random_phase(input int s_idle, input int r_idle);
        int unsigned roll;
        int unsigned bytes;
        int unsigned k;
        int unsigned j;
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        repeat (PHASE_ITEMS) begin
            roll = $urandom_range(99);
            if (orphan_slots.size() > 0 && $urandom_range(1)) begin
                send_request(OP_RELEASE, $urandom_range(REQ_TOP), $urandom_range(1),
                             orphan_slots.pop_front(), 1'b0);
            end else if (roll < 8) begin
                k = $urandom_range(3);
                bytes = (t_op'(k) == OP_ALLOC && $urandom_range(1)) ?
                        $urandom_range(REQ_TOP, OVERSIZE_MIN) :
                        (t_op'(k) == OP_ALLOC) ? $urandom_range(SMALL_TOP) :
                        $urandom_range(REQ_TOP);
                send_request(t_op'(k), bytes, $urandom_range(1),
                             $urandom_range(TOP_SLOT), 1'b0);
            end else if (live_slot.size() == 0 || (roll < 50 && live_slot.size() < MAX_LIVE))
            begin
                roll = $urandom_range(99);
                if (roll < 50)
                    bytes = $urandom_range(SMALL_TOP);
                else if (roll < 92)
                    bytes = $urandom_range(MEDIUM_TOP, SMALL_TOP + 1);
                else if (roll < 97)
                    bytes = bytes_for($urandom_range(8, 1)) + $urandom_range(1);
                else
                    bytes = $urandom_range(REQ_TOP, OVERSIZE_MIN);
                send_request(OP_ALLOC, bytes, $urandom_range(1),
                             $urandom_range(TOP_SLOT), 1'b1);
            end else begin
                k = $urandom_range(live_slot.size() - 1);
                if (roll < 72) begin
                    live_refs[k]++;
                    send_request(OP_RETAIN, $urandom_range(REQ_TOP), $urandom_range(1),
                                 live_slot[k], 1'b0);
                end else begin
                    send_request(OP_RELEASE, $urandom_range(REQ_TOP), $urandom_range(1),
                                 live_slot[k], 1'b0);
                    if (live_refs[k] == 0) begin
                        for (j = 1; j < live_len[k]; j++)
                            orphan_slots.push_back(live_slot[k] + j);
                        live_slot.delete(k);
                        live_refs.delete(k);
                        live_len.delete(k);
                    end else begin
                        live_refs[k]--;
                    end
                end
            end
        end
    endtask

    initial begin : stimulus
        int s;
        req_ch.valid          = 1'b0;
        req_ch.operation      = OP_UNUSED;
        req_ch.request_bytes  = '0;
        req_ch.has_destructor = 1'b0;
        req_ch.slot_index     = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Run length limit: just over it, and a request the size of the whole store
        send_request(OP_ALLOC, OVERSIZE_MIN, 1'b0, 0, 1'b0);
        send_request(OP_ALLOC, REQ_TOP, 1'b1, TOP_SLOT, 1'b0);
        // Smallest object lands on the first slot past the reserved ones
        send_request(OP_ALLOC, 0, 1'b1, 0, 1'b0);
        // Free it with its destructor, release it again while free, then bring it back
        // from free and free it once more: the old destructor flag must still show
        send_request(OP_RELEASE, 0, 1'b0, RESERVED_SLOTS, 1'b0);
        send_request(OP_RELEASE, 0, 1'b0, RESERVED_SLOTS, 1'b0);
        send_request(OP_RETAIN, 0, 1'b0, RESERVED_SLOTS, 1'b0);
        send_request(OP_RELEASE, 0, 1'b0, RESERVED_SLOTS, 1'b0);
        // Hold one free slot by retaining it; a three-slot run must step past it
        send_request(OP_RETAIN, 0, 1'b0, RESERVED_SLOTS + 2, 1'b0);
        send_request(OP_ALLOC, bytes_for(3), 1'b1, 0, 1'b0);
        // Give back the held slot and the run slot by slot
        for (s = RESERVED_SLOTS + 2; s < RESERVED_SLOTS + 6; s++)
            send_request(OP_RELEASE, 0, 1'b0, s, 1'b0);
        // Count up and down on the last slot
        send_request(OP_RETAIN, 0, 1'b0, TOP_SLOT, 1'b0);
        send_request(OP_RELEASE, 0, 1'b0, TOP_SLOT, 1'b0);
        send_request(OP_RELEASE, 0, 1'b0, TOP_SLOT, 1'b0);
        // Reserved slots take retain and release like any other
        send_request(OP_RETAIN, 0, 1'b0, 0, 1'b0);
        send_request(OP_RELEASE, 0, 1'b0, 0, 1'b0);
        send_request(OP_RELEASE, 0, 1'b0, 1, 1'b0);
        send_request(OP_UNUSED, $urandom_range(REQ_TOP), $urandom_range(1),
                     $urandom_range(TOP_SLOT), 1'b0);

        random_phase(7, 71);
        random_phase(71, 7);
        random_phase(0, 0);

        @(negedge i_clk);
        req_ch.valid = 1'b0;
        while (expected_left != 0)
            @(negedge i_clk);
        // Hold a little longer to catch any stray result
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
